>>> sv/assert_macros.svh
// Assertion helpers shared by the block's modules.
// Both expect a signal named clk in scope; RMA_CHECK also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define RMA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RMA_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rma_pkg.sv
package rma_pkg;

	// item modes
	localparam logic [1:0] MODE_WEIGHT  = 2'd0;
	localparam logic [1:0] MODE_BIAS    = 2'd1;
	localparam logic [1:0] MODE_FEATURE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
	localparam logic [2:0] REG_WIDTH_ONE   = 3'd2;
	localparam logic [2:0] REG_WIDTH_TWO   = 3'd3;
	localparam logic [2:0] REG_WIDTH_THREE = 3'd4;
	localparam logic [2:0] REG_WIDTH_FOUR  = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 5;
	localparam int COUNT_REG_W = 3;
	localparam int WIDTH_REG_W = 5;
	localparam int WIDTH_REGS  = 4;

	localparam logic [COUNT_REG_W-1:0] LAYER_COUNT_RST = 3'd2;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST       = 5'd16;

	localparam int LAYER_SEL_W = 2;
	localparam int ROW_W       = 4;
	localparam int COL_W       = 4;
	localparam int DECISION_W  = 4;
	localparam int BEST_W      = 15;

	localparam int ACC_W  = 40;
	localparam int W_FRAC = 12;
	localparam int A_FRAC = 8;

	typedef struct packed {
		logic valid;
		logic first;
		logic bias_op;
		logic last_layer;
		logic src_feat;
		logic src_pong;
		logic dst_pong;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_status_t;

endpackage

>>> sv/rma_ram.sv
module rma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/rma_ctrl.sv
`include "assert_macros.svh"

module rma_ctrl #(
	parameter int MAX_LAYERS = 4,
	parameter int MAX_WIDTH  = 16,
	localparam int IW  = $clog2(MAX_WIDTH),
	localparam int CW  = $clog2(MAX_WIDTH + 1),
	localparam int LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
	localparam int LCW = $clog2(MAX_LAYERS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_accept,
	input  logic [1:0]                      mode,
	input  logic                            last,
	output logic                            in_stall,
	output rma_pkg::mac_cmd_t               cmd,
	output logic [LW-1:0]                   cmd_layer,
	output logic [IW-1:0]                   cmd_row,
	output logic [IW-1:0]                   cmd_col,
	output logic                            emit,
	input  rma_pkg::dp_status_t             status
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [rma_pkg::COUNT_REG_W-1:0] layer_count_q;
	logic [rma_pkg::WIDTH_REG_W-1:0] input_width_q;
	logic [rma_pkg::WIDTH_REG_W-1:0] width_q [rma_pkg::WIDTH_REGS];

	logic [LW-1:0] layer_q;
	logic [IW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] n_in_q;
	logic [CW-1:0] n_out;
	logic [LCW-1:0] layers;
	logic          last_layer, last_row, mac_phase, start;

	function automatic logic [CW-1:0] clamp_w(input logic [rma_pkg::WIDTH_REG_W-1:0] w);
		logic [CW-1:0] r;
		if (w == '0) begin
			r = CW'(1);
		end else if (int'(w) > MAX_WIDTH) begin
			r = CW'(MAX_WIDTH);
		end else begin
			r = CW'(w);
		end
		return r;
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= rma_pkg::LAYER_COUNT_RST;
			input_width_q <= rma_pkg::WIDTH_RST;
			for (int k = 0; k < rma_pkg::WIDTH_REGS; k++) begin
				width_q[k] <= rma_pkg::WIDTH_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				rma_pkg::REG_LAYER_COUNT: layer_count_q <= rma_pkg::COUNT_REG_W'(cfg_data);
				rma_pkg::REG_INPUT_WIDTH: input_width_q <= cfg_data;
				rma_pkg::REG_WIDTH_ONE:   width_q[0] <= cfg_data;
				rma_pkg::REG_WIDTH_TWO:   width_q[1] <= cfg_data;
				rma_pkg::REG_WIDTH_THREE: width_q[2] <= cfg_data;
				rma_pkg::REG_WIDTH_FOUR:  width_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (layer_count_q == '0) begin
			layers = LCW'(1);
		end else if (int'(layer_count_q) > MAX_LAYERS) begin
			layers = LCW'(MAX_LAYERS);
		end else begin
			layers = LCW'(layer_count_q);
		end
		// layers past the fourth run at full width
		n_out = CW'(MAX_WIDTH);
		for (int k = 0; k < rma_pkg::WIDTH_REGS; k++) begin
			if (int'(layer_q) == k) begin
				n_out = clamp_w(width_q[k]);
			end
		end
	end

	assign last_layer = (LCW'(layer_q) == layers - LCW'(1));
	assign last_row   = (CW'(row_q) == n_out - CW'(1));
	assign mac_phase  = (col_q != n_in_q);
	assign start      = in_accept && (mode == rma_pkg::MODE_FEATURE) && last;
	assign in_stall   = (state_q != ST_IDLE);
	assign emit       = (state_q == ST_EMIT) && status.out_free;

	assign cmd_layer = layer_q;
	assign cmd_row   = row_q;
	assign cmd_col   = IW'(col_q);

	always_comb begin
		cmd            = '0;
		cmd.valid      = (state_q == ST_ISSUE);
		cmd.first      = mac_phase && (col_q == '0);
		cmd.bias_op    = !mac_phase;
		cmd.last_layer = last_layer;
		cmd.src_feat   = (layer_q == '0);
		cmd.src_pong   = !layer_q[0];
		cmd.dst_pong   = layer_q[0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_ISSUE;
			ST_ISSUE: if (!mac_phase && last_row) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = last_layer ? ST_EMIT : ST_ISSUE;
				end
			end
			ST_EMIT:  if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			n_in_q  <= CW'(1);
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				layer_q <= '0;
				row_q   <= '0;
				col_q   <= '0;
				n_in_q  <= clamp_w(input_width_q);
			end else if (state_q == ST_ISSUE) begin
				if (mac_phase) begin
					col_q <= col_q + CW'(1);
				end else begin
					col_q <= '0;
					if (!last_row) begin
						row_q <= row_q + IW'(1);
					end
				end
			end else if (state_q == ST_DRAIN && !status.busy && !last_layer) begin
				layer_q <= layer_q + LW'(1);
				row_q   <= '0;
				col_q   <= '0;
				n_in_q  <= n_out;
			end
		end
	end

	`RMA_CHECK(a_issue_blocks_input, cmd.valid |-> in_stall, "issue while input open")
	`RMA_CHECK(a_emit_into_free, emit |-> status.out_free, "emit into a full output")

endmodule

>>> sv/rma_dp.sv
`include "assert_macros.svh"

module rma_dp #(
	parameter int MAX_LAYERS = 4,
	parameter int MAX_WIDTH  = 16,
	parameter int DATA_BITS  = 16,
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_accept,
	input  logic [1:0]                      mode,
	input  logic [rma_pkg::LAYER_SEL_W-1:0] layer_sel,
	input  logic [rma_pkg::ROW_W-1:0]       neuron_row,
	input  logic [rma_pkg::COL_W-1:0]       column,
	input  logic signed [DATA_BITS-1:0]     word_value,
	input  rma_pkg::mac_cmd_t               cmd,
	input  logic [LW-1:0]                   cmd_layer,
	input  logic [IW-1:0]                   cmd_row,
	input  logic [IW-1:0]                   cmd_col,
	input  logic                            emit,
	output rma_pkg::dp_status_t             status,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [rma_pkg::DECISION_W-1:0]  decision,
	output logic [rma_pkg::BEST_W-1:0]      best_activation
);

	localparam int WDEPTH = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
	localparam int BDEPTH = MAX_LAYERS * MAX_WIDTH;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int BAW    = $clog2(BDEPTH);
	localparam int AW     = (2 * DATA_BITS > rma_pkg::ACC_W) ? 2 * DATA_BITS : rma_pkg::ACC_W;
	localparam int SW     = AW + 1;
	localparam logic signed [SW-1:0] ACC_HI = SW'((64'sd1 <<< (rma_pkg::ACC_W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);
	localparam logic [rma_pkg::ACC_W-1:0] ACT_MAX =
		rma_pkg::ACC_W'((64'd1 << (DATA_BITS - 1)) - 64'd1);

	// load decode
	logic ld_ok_layer, ld_ok_row, ld_ok_col;
	logic w_we, b_we, f_we;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [DATA_BITS-1:0] w_rdata, b_rdata;

	assign ld_ok_layer = int'(layer_sel) < MAX_LAYERS;
	assign ld_ok_row   = int'(neuron_row) < MAX_WIDTH;
	assign ld_ok_col   = int'(column) < MAX_WIDTH;
	assign w_we = in_accept && mode == rma_pkg::MODE_WEIGHT && ld_ok_layer && ld_ok_row
		&& ld_ok_col;
	assign b_we = in_accept && mode == rma_pkg::MODE_BIAS && ld_ok_layer && ld_ok_row;
	assign f_we = in_accept && mode == rma_pkg::MODE_FEATURE && ld_ok_col;

	assign w_waddr = WAW'((int'(layer_sel) * MAX_WIDTH + int'(neuron_row)) * MAX_WIDTH
		+ int'(column));
	assign b_waddr = BAW'(int'(layer_sel) * MAX_WIDTH + int'(neuron_row));
	assign w_raddr = WAW'((int'(cmd_layer) * MAX_WIDTH + int'(cmd_row)) * MAX_WIDTH
		+ int'(cmd_col));
	assign b_raddr = BAW'(int'(cmd_layer) * MAX_WIDTH + int'(cmd_row));

	rma_ram #(.WIDTH(DATA_BITS), .DEPTH(WDEPTH)) u_weights (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(word_value),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	rma_ram #(.WIDTH(DATA_BITS), .DEPTH(BDEPTH)) u_biases (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(word_value),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	// vectors
	logic [DATA_BITS-1:0] feat_q [MAX_WIDTH];
	logic [DATA_BITS-1:0] ping_q [MAX_WIDTH];
	logic [DATA_BITS-1:0] pong_q [MAX_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WIDTH; k++) begin
				feat_q[k] <= '0;
			end
		end else if (emit) begin
			for (int k = 0; k < MAX_WIDTH; k++) begin
				feat_q[k] <= '0;
			end
		end else if (f_we) begin
			feat_q[IW'(column)] <= word_value;
		end
	end

	// stage 1: operand fetch
	rma_pkg::mac_cmd_t cmd_s1, cmd_s2;
	logic [IW-1:0] row_s1, row_s2, row_s3;
	logic signed [DATA_BITS-1:0] src_s1;
	logic end_s3, last_layer_s3, dst_pong_s3;

	always_ff @(posedge clk) begin
		if (cmd.src_feat) begin
			src_s1 <= feat_q[cmd_col];
		end else if (cmd.src_pong) begin
			src_s1 <= pong_q[cmd_col];
		end else begin
			src_s1 <= ping_q[cmd_col];
		end
		row_s1 <= cmd_row;
	end

	// stage 2: product or scaled bias
	logic signed [2*DATA_BITS-1:0] prod;
	logic signed [AW-1:0] addend_s2;

	assign prod = $signed(w_rdata) * src_s1;

	always_ff @(posedge clk) begin
		if (cmd_s1.bias_op) begin
			addend_s2 <= AW'($signed(b_rdata)) <<< rma_pkg::A_FRAC;
		end else begin
			addend_s2 <= AW'(prod);
		end
		row_s2 <= row_s1;
	end

	// stage 3: saturating accumulate
	logic signed [rma_pkg::ACC_W-1:0] acc_q;
	logic signed [SW-1:0] sum;

	always_comb begin
		sum = (cmd_s2.first ? '0 : SW'(acc_q)) + SW'(addend_s2);
		if (sum > ACC_HI) begin
			sum = ACC_HI;
		end else if (sum < ACC_LO) begin
			sum = ACC_LO;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_s2.valid) begin
			acc_q <= rma_pkg::ACC_W'(sum);
		end
		row_s3        <= row_s2;
		last_layer_s3 <= cmd_s2.last_layer;
		dst_pong_s3   <= cmd_s2.dst_pong;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
			end_s3 <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
			end_s3 <= cmd_s2.valid && cmd_s2.bias_op;
		end
	end

	// stage 4: ReLU, write-back, running argmax
	logic [rma_pkg::ACC_W-1:0] shifted;
	logic [DATA_BITS-1:0] act;
	logic [IW-1:0] best_idx_q;
	logic [DATA_BITS-1:0] best_val_q;

	always_comb begin
		shifted = rma_pkg::ACC_W'(acc_q >>> rma_pkg::W_FRAC);
		if (acc_q <= 0) begin
			act = '0;
		end else if (shifted > ACT_MAX) begin
			act = DATA_BITS'(ACT_MAX);
		end else begin
			act = DATA_BITS'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (end_s3) begin
			if (dst_pong_s3) begin
				pong_q[row_s3] <= act;
			end else begin
				ping_q[row_s3] <= act;
			end
			if (last_layer_s3 && (row_s3 == '0 || act > best_val_q)) begin
				best_idx_q <= row_s3;
				best_val_q <= act;
			end
		end
	end

	// output register
	logic out_valid_q;
	logic [rma_pkg::DECISION_W-1:0] decision_q;
	logic [rma_pkg::BEST_W-1:0] best_q;

	assign status = '{
		busy:     cmd_s1.valid || cmd_s2.valid || end_s3,
		out_free: !out_valid_q || !out_stall
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			decision_q <= rma_pkg::DECISION_W'(best_idx_q);
			best_q     <= rma_pkg::BEST_W'(best_val_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign decision        = decision_q;
	assign best_activation = best_q;

	`RMA_CHECK(a_emit_drained, emit |-> !status.busy, "emit with MACs in flight")
	`RMA_CHECK(a_out_from_emit, $rose(out_valid_q) |-> $past(emit), "result without emit")
	`RMA_CHECK_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid_q, "result during reset")

endmodule

>>> sv/relu_mlp_argmax_top.sv
// Fully connected ReLU network with an argmax on the final layer.
// Input channel (in_valid/in_stall): one beat per item. mode selects a weight
// write, a bias write or a feature; a feature beat with last set starts an
// inference. Loads and features are taken back to back while the block is
// idle.
// Inference runs on one shared MAC: each layer reads one weight per cycle
// from the weight RAM port for each output, then that output's bias, and the
// MAC pipeline drains before the next layer reads its inputs; in_stall stays
// high for the whole inference.
// Output channel (out_valid/out_stall): one beat per inference with the
// winning index (lowest on ties) and its activation. The result sits in an
// output register, so a stalled result does not block loads or features;
// only the next result waits for the register to empty.
// Configuration: cfg_we/cfg_index/cfg_data; the user must write it only while idle, the block does not enforce this.
// Reset clears the registers to two layers of width 16, the feature vector
// and the handshake state; weight and bias RAMs hold nothing until loaded.
module relu_mlp_argmax_top #(
	parameter int MAX_LAYERS = 4,
	parameter int MAX_WIDTH  = 16,
	parameter int DATA_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic [rma_pkg::LAYER_SEL_W-1:0] layer_sel,
	input  logic [rma_pkg::ROW_W-1:0]       neuron_row,
	input  logic [rma_pkg::COL_W-1:0]       column,
	input  logic signed [DATA_BITS-1:0]     word_value,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rma_pkg::DECISION_W-1:0]  decision,
	output logic [rma_pkg::BEST_W-1:0]      best_activation
);

	localparam int IW = $clog2(MAX_WIDTH);
	localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

	logic                in_accept;
	rma_pkg::mac_cmd_t   cmd;
	rma_pkg::dp_status_t status;
	logic [LW-1:0]       cmd_layer;
	logic [IW-1:0]       cmd_row, cmd_col;
	logic                emit;

	// a beat lands only while the sequencer is idle
	assign in_accept = in_valid && !in_stall;

	rma_ctrl #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.mode      (mode),
		.last      (last),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.cmd_layer (cmd_layer),
		.cmd_row   (cmd_row),
		.cmd_col   (cmd_col),
		.emit      (emit),
		.status    (status)
	);

	// weight/bias RAMs, vectors, MAC pipeline and result register
	rma_dp #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH), .DATA_BITS(DATA_BITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_accept       (in_accept),
		.mode            (mode),
		.layer_sel       (layer_sel),
		.neuron_row      (neuron_row),
		.column          (column),
		.word_value      (word_value),
		.cmd             (cmd),
		.cmd_layer       (cmd_layer),
		.cmd_row         (cmd_row),
		.cmd_col         (cmd_col),
		.emit            (emit),
		.status          (status),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.decision        (decision),
		.best_activation (best_activation)
	);

endmodule

>>> verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rma_pkg::*;

	// one input beat as the sender offers it
	typedef struct {
		logic [1:0]                  mode;
		logic [LAYER_SEL_W-1:0]      layer;
		logic [ROW_W-1:0]            row;
		logic [COL_W-1:0]            col;
		logic signed [15:0]          word;
		logic                        last;
	} beat_t;

	// one decision as the block should report it
	typedef struct {
		logic [DECISION_W-1:0] decision;
		logic [BEST_W-1:0]     best;
	} verdict_t;

	localparam longint ACC_TOP = 64'sd549755813887;
	localparam longint ACC_BOT = -ACC_TOP - 1;
	localparam longint ACT_TOP = 32767;
	localparam int     CYCLE_LIMIT = 10000000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_WEIGHT;
	logic [LAYER_SEL_W-1:0] layer_sel = '0;
	logic [ROW_W-1:0] neuron_row = '0;
	logic [COL_W-1:0] column = '0;
	logic signed [15:0] word_value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DECISION_W-1:0] decision;
	logic [BEST_W-1:0] best_activation;

	relu_mlp_argmax_top dut (.*);

	always #5 clk = ~clk;

	// network copy kept by the testbench
	longint weight_tab[4][16][16];
	longint bias_tab[4][16];
	longint feature_vec[16];
	int     reg_val[6] = '{2, 16, 16, 16, 16, 16};

	beat_t    pending_beats[$];
	verdict_t expected_verdicts[$];
	beat_t    next_beat;
	int       errors = 0;
	int       cycles = 0;
	int       results_seen = 0;
	int       hold_left = 0;
	bit       hold_done = 0;
	bit       calm;

	// no random idling on either side in this window
	assign calm = (cycles >= 20000) && (cycles < 40000);

	function automatic int clamp_width(int w);
		if (w < 1) return 1;
		if (w > 16) return 16;
		return w;
	endfunction

	function automatic longint sat_add(longint acc, longint v);
		longint s;
		s = acc + v;
		if (s > ACC_TOP) s = ACC_TOP;
		if (s < ACC_BOT) s = ACC_BOT;
		return s;
	endfunction

	// runs the whole network on the feature vector, then clears it
	function automatic verdict_t classify();
		longint src[16];
		longint dst[16];
		longint acc;
		longint act;
		int layers, n_in, n_out, top;
		verdict_t v;
		layers = reg_val[REG_LAYER_COUNT];
		if (layers < 1) layers = 1;
		if (layers > 4) layers = 4;
		n_in = clamp_width(reg_val[REG_INPUT_WIDTH]);
		n_out = 1;
		src = feature_vec;
		dst = '{default: 0};
		for (int l = 0; l < layers; l++) begin
			n_out = clamp_width(reg_val[REG_WIDTH_ONE + l]);
			for (int i = 0; i < n_out; i++) begin
				acc = 0;
				for (int j = 0; j < n_in; j++)
					acc = sat_add(acc, weight_tab[l][i][j] * src[j]);
				acc = sat_add(acc, bias_tab[l][i] * 256);
				if (acc <= 0) act = 0;
				else act = acc >>> W_FRAC;
				dst[i] = (act > ACT_TOP) ? ACT_TOP : act;
			end
			src = dst;
			n_in = n_out;
		end
		top = 0;
		for (int i = 1; i < n_out; i++)
			if (src[i] > src[top]) top = i;
		v.decision = top[DECISION_W-1:0];
		v.best = src[top][BEST_W-1:0];
		feature_vec = '{default: 0};
		return v;
	endfunction

	// applies one accepted beat to the copy of the network
	function automatic void absorb(beat_t b);
		case (b.mode)
			MODE_WEIGHT: weight_tab[b.layer][b.row][b.col] = longint'(b.word);
			MODE_BIAS:   bias_tab[b.layer][b.row] = longint'(b.word);
			MODE_FEATURE: begin
				feature_vec[b.col] = longint'(b.word);
				if (b.last) expected_verdicts = {expected_verdicts, classify()};
			end
			default: ;
		endcase
	endfunction

	// mostly modest values so the network does not just saturate
	function automatic logic signed [15:0] pick_word();
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2048)) - 1024);
	endfunction

	function automatic beat_t make_beat(logic [1:0] m, int l, int r, int c,
			logic signed [15:0] w, logic lst);
		beat_t b;
		b.mode = m;
		b.layer = l[LAYER_SEL_W-1:0];
		b.row = r[ROW_W-1:0];
		b.col = c[COL_W-1:0];
		b.word = w;
		b.last = lst;
		return b;
	endfunction

	function automatic void queue_beat(beat_t b);
		pending_beats = {pending_beats, b};
	endfunction

	// sender: holds a stalled beat, otherwise offers the next one or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				absorb(make_beat(mode, int'(layer_sel), int'(neuron_row), int'(column),
					word_value, last));
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
					next_beat = pending_beats.pop_front();
					in_valid <= 1'b1;
					mode <= next_beat.mode;
					layer_sel <= next_beat.layer;
					neuron_row <= next_beat.row;
					column <= next_beat.col;
					word_value <= next_beat.word;
					last <= next_beat.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off so the block backs up
	always @(posedge clk) begin
		if (!hold_done && results_seen == 30) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			out_stall <= 1'b1;
		end else begin
			if (hold_left > 0) hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1) || (!calm && $urandom_range(0, 99) < 8);
		end
	end

	// decision checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected decision %0d activation %0d", $time,
					decision, best_activation);
				errors++;
			end else begin
				verdict_t e;
				e = expected_verdicts.pop_front();
				if (decision !== e.decision) begin
					$display("%0t: decision expected %0d actual %0d", $time,
						e.decision, decision);
					errors++;
				end
				if (best_activation !== e.best) begin
					$display("%0t: best_activation expected %0d actual %0d", $time,
						e.best, best_activation);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		// the block keeps only the register's own bits
		reg_val[idx] = (idx == REG_LAYER_COUNT) ? (val & 7) : (val & 31);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// block drained: no beats left, nothing owed, then the pipeline pause
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_beats.size() > 0 || in_valid || expected_verdicts.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	// well-formed vectors with random content, plus reloads and noise
	task automatic queue_random(int n);
		int count, r, len;
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				queue_beat(make_beat(MODE_WEIGHT, $urandom_range(0, 3),
					$urandom_range(0, 15), $urandom_range(0, 15), pick_word(),
					1'($urandom)));
				count++;
			end else if (r < 25) begin
				queue_beat(make_beat(MODE_BIAS, $urandom_range(0, 3),
					$urandom_range(0, 15), $urandom, pick_word(), 1'($urandom)));
				count++;
			end else if (r < 28) begin
				queue_beat(make_beat(2'd3, $urandom, $urandom, $urandom,
					16'($urandom), 1'($urandom)));
			end else begin
				len = $urandom_range(1, 16);
				for (int k = 0; k < len; k++)
					queue_beat(make_beat(MODE_FEATURE, $urandom, $urandom,
						$urandom_range(0, 15), pick_word(), k == len - 1));
				count += len;
			end
		end
	endtask

	int plan[8][6] = '{
		'{1, 1, 1, 1, 1, 1},
		'{4, 16, 16, 16, 16, 16},
		'{0, 0, 0, 0, 0, 0},
		'{7, 31, 17, 20, 31, 25},
		'{3, 5, 9, 2, 12, 7},
		'{4, 1, 16, 1, 16, 1},
		'{0, 0, 0, 0, 0, 0},
		'{2, 16, 16, 16, 16, 16}
	};

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// fill both tables so no inference reads an unwritten entry
		for (int l = 0; l < 4; l++)
			for (int r = 0; r < 16; r++) begin
				queue_beat(make_beat(MODE_BIAS, l, r, 0, pick_word(), 1'b0));
				for (int c = 0; c < 16; c++)
					queue_beat(make_beat(MODE_WEIGHT, l, r, c,
						pick_word(), 1'b0));
			end

		// directed: extremes, last on loads, mode three, partial vectors
		queue_beat(make_beat(MODE_WEIGHT, 3, 15, 15, 16'sh7fff, 1'b1));
		queue_beat(make_beat(MODE_WEIGHT, 0, 0, 0, 16'sh8000, 1'b1));
		queue_beat(make_beat(MODE_BIAS, 0, 15, 0, 16'sh7fff, 1'b1));
		queue_beat(make_beat(MODE_BIAS, 1, 0, 0, 16'sh8000, 1'b0));
		queue_beat(make_beat(2'd3, 3, 15, 15, 16'shffff, 1'b1));
		queue_beat(make_beat(MODE_FEATURE, 0, 0, 0, 16'sh7fff, 1'b0));
		queue_beat(make_beat(MODE_FEATURE, 0, 0, 15, 16'sh8000, 1'b1));
		queue_beat(make_beat(MODE_FEATURE, 3, 15, 7, 16'sh0100, 1'b1));
		queue_beat(make_beat(MODE_FEATURE, 0, 0, 3, 16'sh0000, 1'b1));
		for (int c = 0; c < 16; c++)
			queue_beat(make_beat(MODE_FEATURE, 0, 0, c, 16'sh7fff, c == 15));
		queue_random(100);
		wait_drained();

		// later sets include clamped out-of-range values and one random set
		for (int p = 0; p < 8; p++) begin
			if (p == 6)
				for (int i = 0; i < 6; i++) plan[p][i] = $urandom_range(0, 31);
			for (int i = 0; i < 6; i++) write_reg(i[CFG_INDEX_W-1:0], plan[p][i]);
			queue_random(100);
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

>>> relu_mlp_argmax_top.f
+incdir+sv
sv/rma_pkg.sv
sv/rma_ram.sv
sv/rma_ctrl.sv
sv/rma_dp.sv
sv/relu_mlp_argmax_top.sv
verif/tb.sv
